[rtl/sblit_pkg.sv]
// ----------------------------------------------------------------------------
// sblit_pkg
// Shared types and constants of the color-key sprite blitter back end.
// ----------------------------------------------------------------------------
package sblit_pkg;

    // Screen geometry and region limits
    localparam int SCREEN_W   = 320;
    localparam int SCREEN_H   = 200;
    localparam int MAX_REGION = 1024;

    // Counter and coordinate widths
    localparam int CNT_W  = $clog2(MAX_REGION);      // column / row counter
    localparam int SIZE_W = 11;                      // region_w / region_h field
    localparam int VW_W   = 9;                       // view_w field
    localparam int VH_W   = 8;                       // view_h field
    localparam int POS_W  = 16;                      // dest_x / dest_y field
    localparam int SX_W   = POS_W + 1;               // screen coordinate, signed
    localparam int XI_W   = $clog2(SCREEN_W);        // in-screen column bits
    localparam int YI_W   = $clog2(SCREEN_H);        // in-screen row bits
    localparam int ADDR_W = 16;
    localparam int PIX_W  = 8;
    localparam int MODE_W = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEST_X     = 3'd0,
        REG_DEST_Y     = 3'd1,
        REG_REGION_W   = 3'd2,
        REG_REGION_H   = 3'd3,
        REG_VIEW_W     = 3'd4,
        REG_VIEW_H     = 3'd5,
        REG_COLOR_KEY  = 3'd6,
        REG_FILL_COLOR = 3'd7
    } t_reg_idx;

    // Drawing modes; bit 1 selects fill, any nonzero mode is keyed
    localparam logic [MODE_W-1:0] MODE_OPAQUE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_KEYED  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FILL   = 2'd2;
    localparam int                MODE_FILL_BIT = 1;

    // Effective (clamped / saturated) configuration
    typedef struct packed {
        logic signed [POS_W-1:0]  dest_x;
        logic signed [POS_W-1:0]  dest_y;
        logic [SIZE_W-1:0]        w;
        logic [SIZE_W-1:0]        h;
        logic [VW_W-1:0]          vw;
        logic [VH_W-1:0]          vh;
        logic [PIX_W-1:0]         color_key;
        logic [PIX_W-1:0]         fill_color;
    } t_cfg;

    // One placed source pixel, held in the input stage
    typedef struct packed {
        logic [PIX_W-1:0]  pixel;
        logic [MODE_W-1:0] mode;
        logic [CNT_W-1:0]  col;
        logic [CNT_W-1:0]  row;
        logic              last;
    } t_item;

    // One framebuffer write result
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pixel;
        logic              last;
    } t_result;

endpackage

[rtl/sblit_cfg.sv]
// ----------------------------------------------------------------------------
// sblit_cfg
// Configuration registers with region clamp and viewport saturation.
// ----------------------------------------------------------------------------
module sblit_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr,
    input  logic [sblit_pkg::CFG_IDX_W-1:0]     i_idx,
    input  logic [sblit_pkg::CFG_DATA_W-1:0]    i_data,
    output sblit_pkg::t_cfg                     o_cfg
);

    logic signed [sblit_pkg::POS_W-1:0] r_dest_x, r_dest_y;
    logic [sblit_pkg::SIZE_W-1:0]       r_region_w, r_region_h;
    logic [sblit_pkg::VW_W-1:0]         r_view_w;
    logic [sblit_pkg::VH_W-1:0]         r_view_h;
    logic [sblit_pkg::PIX_W-1:0]        r_color_key, r_fill_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_x     <= '0;
            r_dest_y     <= '0;
            r_region_w   <= sblit_pkg::SIZE_W'(1);
            r_region_h   <= sblit_pkg::SIZE_W'(1);
            r_view_w     <= sblit_pkg::VW_W'(sblit_pkg::SCREEN_W);
            r_view_h     <= sblit_pkg::VH_W'(sblit_pkg::SCREEN_H);
            r_color_key  <= '0;
            r_fill_color <= '0;
        end else if (i_wr) begin
            case (sblit_pkg::t_reg_idx'(i_idx))
                sblit_pkg::REG_DEST_X:     r_dest_x     <= i_data;
                sblit_pkg::REG_DEST_Y:     r_dest_y     <= i_data;
                sblit_pkg::REG_REGION_W:   r_region_w   <= i_data[sblit_pkg::SIZE_W-1:0];
                sblit_pkg::REG_REGION_H:   r_region_h   <= i_data[sblit_pkg::SIZE_W-1:0];
                sblit_pkg::REG_VIEW_W:     r_view_w     <= i_data[sblit_pkg::VW_W-1:0];
                sblit_pkg::REG_VIEW_H:     r_view_h     <= i_data[sblit_pkg::VH_W-1:0];
                sblit_pkg::REG_COLOR_KEY:  r_color_key  <= i_data[sblit_pkg::PIX_W-1:0];
                sblit_pkg::REG_FILL_COLOR: r_fill_color <= i_data[sblit_pkg::PIX_W-1:0];
                default: ;
            endcase
        end
    end

    function automatic logic [sblit_pkg::SIZE_W-1:0] clamp_size(
        input logic [sblit_pkg::SIZE_W-1:0] v
    );
        if (v == '0)
            return sblit_pkg::SIZE_W'(1);
        if (v > sblit_pkg::SIZE_W'(sblit_pkg::MAX_REGION))
            return sblit_pkg::SIZE_W'(sblit_pkg::MAX_REGION);
        return v;
    endfunction

    always_comb begin
        o_cfg.dest_x     = r_dest_x;
        o_cfg.dest_y     = r_dest_y;
        o_cfg.w          = clamp_size(r_region_w);
        o_cfg.h          = clamp_size(r_region_h);
        o_cfg.vw         = (r_view_w > sblit_pkg::VW_W'(sblit_pkg::SCREEN_W))
                         ? sblit_pkg::VW_W'(sblit_pkg::SCREEN_W) : r_view_w;
        o_cfg.vh         = (r_view_h > sblit_pkg::VH_W'(sblit_pkg::SCREEN_H))
                         ? sblit_pkg::VH_W'(sblit_pkg::SCREEN_H) : r_view_h;
        o_cfg.color_key  = r_color_key;
        o_cfg.fill_color = r_fill_color;
    end

endmodule

[rtl/sblit_pos.sv]
// ----------------------------------------------------------------------------
// sblit_pos
// Column and row counters over the region, advanced once per input pixel.
// ----------------------------------------------------------------------------
module sblit_pos (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  logic [sblit_pkg::SIZE_W-1:0]    i_w,
    input  logic [sblit_pkg::SIZE_W-1:0]    i_h,
    output logic [sblit_pkg::CNT_W-1:0]     o_col,
    output logic [sblit_pkg::CNT_W-1:0]     o_row,
    output logic                            o_last
);

    logic [sblit_pkg::CNT_W-1:0]  r_col, r_row;
    logic [sblit_pkg::CNT_W-1:0]  n_col, n_row;
    logic [sblit_pkg::SIZE_W-1:0] col_inc, row_inc;
    logic                         col_end, row_end;

    // a counter at or past the last index (region shrunk) counts as the end
    assign col_inc = sblit_pkg::SIZE_W'(r_col) + sblit_pkg::SIZE_W'(1);
    assign row_inc = sblit_pkg::SIZE_W'(r_row) + sblit_pkg::SIZE_W'(1);
    assign col_end = (col_inc >= i_w);
    assign row_end = (row_inc >= i_h);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_step) begin
            if (col_end) begin
                n_col = '0;
                n_row = row_end ? '0 : row_inc[sblit_pkg::CNT_W-1:0];
            end else begin
                n_col = col_inc[sblit_pkg::CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_col  = r_col;
    assign o_row  = r_row;
    assign o_last = col_end && row_end;

endmodule

[rtl/sblit_eval.sv]
// ----------------------------------------------------------------------------
// sblit_eval
// Viewport and color-key test, address generation and result register.
// ----------------------------------------------------------------------------
module sblit_eval (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sblit_pkg::t_cfg     i_cfg,
    input  logic                i_valid,
    input  sblit_pkg::t_item    i_item,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    output sblit_pkg::t_result  o_res
);

    logic signed [sblit_pkg::SX_W-1:0] sx, sy;
    logic                              in_view, keyed, fill, we;
    logic [sblit_pkg::ADDR_W-1:0]      addr_full;
    sblit_pkg::t_result                n_res;
    sblit_pkg::t_result                r_res;
    logic                              r_valid;

    // sign-extend the position, zero-extend the counter
    assign sx = $signed({i_cfg.dest_x[sblit_pkg::POS_W-1], i_cfg.dest_x})
              + $signed({{(sblit_pkg::SX_W-sblit_pkg::CNT_W){1'b0}}, i_item.col});
    assign sy = $signed({i_cfg.dest_y[sblit_pkg::POS_W-1], i_cfg.dest_y})
              + $signed({{(sblit_pkg::SX_W-sblit_pkg::CNT_W){1'b0}}, i_item.row});

    assign in_view = !sx[sblit_pkg::SX_W-1] && !sy[sblit_pkg::SX_W-1]
                  && ($unsigned(sx) < sblit_pkg::SX_W'(i_cfg.vw))
                  && ($unsigned(sy) < sblit_pkg::SX_W'(i_cfg.vh));

    assign keyed = (i_item.mode != sblit_pkg::MODE_OPAQUE);
    assign fill  = i_item.mode[sblit_pkg::MODE_FILL_BIT];
    assign we    = in_view && !(keyed && (i_item.pixel == i_cfg.color_key));

    // inside the viewport the low coordinate bits are exact; constant multiply
    assign addr_full = sblit_pkg::ADDR_W'(sy[sblit_pkg::YI_W-1:0])
                     * sblit_pkg::ADDR_W'(sblit_pkg::SCREEN_W)
                     + sblit_pkg::ADDR_W'(sx[sblit_pkg::XI_W-1:0]);

    always_comb begin
        n_res.we    = we;
        n_res.addr  = we ? addr_full : '0;
        n_res.pixel = we ? (fill ? i_cfg.fill_color : i_item.pixel) : '0;
        n_res.last  = i_item.last;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

[rtl/sprite_blit_clip_colorkey_core.sv]
// ----------------------------------------------------------------------------
// sprite_blit_clip_colorkey_core
// Color-key sprite blitter back end: places, clips and keys a pixel stream.
// ----------------------------------------------------------------------------
// Source pixels of one region arrive in raster order on the slave stream,
// tagged with a mode in tuser (opaque copy, keyed copy, keyed solid fill).
// Each transaction yields exactly one framebuffer write transaction on the
// master stream: a write enable, the address row * 320 + column, the color
// and tlast on the region's last pixel. Throughput is one pixel per clock
// while the sink is ready. A pixel passes the input register (which also
// snapshots the column/row counters) and then the result register behind
// the viewport test and constant-multiply address adder. While a result
// waits on the sink, the pipeline fills with two pixels and the slave side then
// drops tready; slave tready follows master tready combinationally, so no
// bubble appears once the sink resumes. The configuration channel is
// always ready and writes take effect at once; write only while the stream
// is idle. Counters are untouched by register writes.
// ----------------------------------------------------------------------------
module sprite_blit_clip_colorkey_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [7:0]                          i_s_tdata,   // [7:0] src_pixel
    input  logic [1:0]                          i_s_tuser,   // [1:0] mode
    // master stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [23:0]                         o_m_tdata,   // [15:0] fb_address, [23:16] pixel_out
    output logic                                o_m_tuser,   // [0] write_enable
    output logic                                o_m_tlast,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sblit_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sblit_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    sblit_pkg::t_cfg    cfg;
    sblit_pkg::t_item   n_item;
    sblit_pkg::t_item   r_item;
    sblit_pkg::t_result res;
    logic               r_s1_valid;
    logic               eval_ready;
    logic               s_accept;
    logic [sblit_pkg::CNT_W-1:0] col, row;
    logic               last;

    assign o_cfg_ready = 1'b1;

    sblit_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_idx   (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // input stage frees up whenever the result stage can take its content
    assign o_s_tready = !r_s1_valid || eval_ready;
    assign s_accept   = i_s_tvalid && o_s_tready;

    // counters step once per accepted transaction
    sblit_pos u_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (s_accept),
        .i_w     (cfg.w),
        .i_h     (cfg.h),
        .o_col   (col),
        .o_row   (row),
        .o_last  (last)
    );

    always_comb begin
        n_item.pixel = i_s_tdata;
        n_item.mode  = i_s_tuser;
        n_item.col   = col;
        n_item.row   = row;
        n_item.last  = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_item <= n_item;
        end
    end

    sblit_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (r_s1_valid),
        .i_item  (r_item),
        .o_ready (eval_ready),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (res)
    );

    assign o_m_tdata = {res.pixel, res.addr};
    assign o_m_tuser = res.we;
    assign o_m_tlast = res.last;

endmodule
